// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;

	// opcodes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// request word
	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] store_value;
	} req_t;

	// response word
	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	// lookup sent to the directory
	typedef struct packed {
		logic             en;
		logic             put;
		logic [KEY_W-1:0] key;
	} dir_req_t;

	// directory answer: hit flag and the slot to read or write
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} dir_res_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache: a new request word is held off while the previous one is in stage 1,
// and while a get waits in stage 2 for the output register. A get result passes through
// the stage 1 request register (directory lookup), the registered value memory read and the output register.
// A put gives no response word; the next request may be taken once the put has left stage 1.
// Reset clears valid marks, ranks and the count, and sets capacity to 16;
// no clearing pass is needed, so requests are taken straight after reset.
module lru_key_value_cache (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lkvc_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lkvc_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lkvc_pkg::CNT_W-1:0] cfg_data
);
	import lkvc_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	logic             s1_valid_q;
	req_t             req_s1;
	logic             s2_valid_q;
	logic             found_s2;
	logic [VAL_W-1:0] rdata_s2;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             out_free;
	logic             accept;
	dir_req_t         dreq;
	dir_res_t         dres;

	logic [VAL_W-1:0] val_mem [ENTRIES];

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q || (s2_valid_q && !out_free);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = !s1_valid_q && !s2_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// capacity register; its effective value is clamped to 1..ENTRIES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(ENTRIES);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CNT_W'(ENTRIES)) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = cap_q;
		end
	end

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// directory lookup and update
	assign dreq.en  = s1_valid_q;
	assign dreq.put = (req_s1.opcode == OP_PUT);
	assign dreq.key = req_s1.lookup_key;

	lkvc_dir u_dir (
		.clk     (clk),
		.arst_n  (arst_n),
		.dreq    (dreq),
		.cap_eff (cap_eff),
		.dres    (dres)
	);

	// value memory: write on put, registered read on get hit
	always_ff @(posedge clk) begin
		if (s1_valid_q && req_s1.opcode == OP_PUT) begin
			val_mem[dres.slot] <= req_s1.store_value;
		end
		if (s1_valid_q && req_s1.opcode == OP_GET && dres.hit) begin
			rdata_s2 <= val_mem[dres.slot];
		end
	end

	// stage 2: get waiting for memory data / output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_valid_q && req_s1.opcode == OP_GET) begin
			s2_valid_q <= 1'b1;
		end else if (out_free) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && req_s1.opcode == OP_GET) begin
			found_s2 <= dres.hit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s2_valid_q && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid_q && out_free) begin
			rsp_q.found      <= found_s2;
			rsp_q.read_value <= found_s2 ? rdata_s2 : '0;
		end
	end

endmodule

// ===== rtl/lkvc_dir.sv =====
// Key directory: tags, valid marks, recency ranks and occupancy count.
module lkvc_dir (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkvc_pkg::dir_req_t      dreq,
	input  logic [lkvc_pkg::CNT_W-1:0] cap_eff,
	output lkvc_pkg::dir_res_t      dres
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0]  key_q   [ENTRIES];
	logic [SLOT_W-1:0] rank_q  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]  occ_q;

	logic [ENTRIES-1:0] match;
	logic [SLOT_W-1:0] hit_slot;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] victim_slot;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  occ_m1;
	logic [CNT_W-1:0]  thresh;
	logic              hit;
	logic              full;
	logic              upd;
	logic              ins;

	// parallel tag compare and slot encoders
	always_comb begin
		hit_slot    = '0;
		free_slot   = '0;
		victim_slot = '0;
		occ_m1      = occ_q - CNT_W'(1);
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == dreq.key);
			if (match[i]) begin
				hit_slot = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
			// least recent entry holds the highest rank, occ-1
			if (valid_q[i] && (CNT_W'(rank_q[i]) == occ_m1)) begin
				victim_slot = SLOT_W'(i);
			end
		end
	end

	// pick slot and ageing threshold
	always_comb begin
		hit  = |match;
		full = (occ_q >= cap_eff);
		if (hit) begin
			slot   = hit_slot;
			thresh = CNT_W'(rank_q[hit_slot]);
		end else if (full) begin
			slot   = victim_slot;
			thresh = occ_m1;
		end else begin
			slot   = free_slot;
			thresh = occ_q;
		end
		upd = dreq.en && (hit || dreq.put);
		ins = dreq.en && dreq.put && !hit;
	end

	assign dres.hit  = hit;
	assign dres.slot = slot;

	// valid marks, ranks and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (SLOT_W'(i) == slot) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (CNT_W'(rank_q[i]) < thresh)) begin
					rank_q[i] <= rank_q[i] + SLOT_W'(1);
				end
			end
			if (ins) begin
				valid_q[slot] <= 1'b1;
				if (!full) begin
					occ_q <= occ_q + CNT_W'(1);
				end
			end
		end
	end

	// tags: written on insertion only
	always_ff @(posedge clk) begin
		if (ins) begin
			key_q[slot] <= dreq.key;
		end
	end

endmodule

// ===== rtl/lkvc_chk.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkvc_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lkvc_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  lkvc_pkg::rsp_t rsp
);
	import lkvc_pkg::*;

	// stage 1 holds one request at a time: stall follows every accepted word
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken without stall in the next cycle");

	// a get leads to a response word once it has passed the stage 1, stage 2 and output registers
	a_get_answers: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.opcode == OP_GET |-> ##3 rsp_valid)
		else $error("get without response word");

	// stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	// no response word while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind lru_key_value_cache lkvc_chk u_lkvc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
